### hdl/srr_pkg.sv
// Shared types, constants and the control program of the selective-repeat receiver.
package srr_pkg;

	// Default sizing of the sequence space and of the stored payload.
	localparam int SEQ_SPACE_DEF    = 8;
	localparam int PAYLOAD_BITS_DEF = 64;

	// Fixed field widths at the block boundary.
	localparam int SEQ_W  = 3;
	localparam int WORD_W = 64;
	localparam int WIN_W  = 3;

	// At most this many payloads are released by one packet.
	localparam int MAX_DELIVER = 7;
	localparam int CNT_W       = 3;

	// Step counter of the control program.
	localparam int PC_W = 3;

	localparam logic [PC_W-1:0] STEP_WAIT     = 3'd0;
	localparam logic [PC_W-1:0] STEP_SCREEN   = 3'd1;
	localparam logic [PC_W-1:0] STEP_ROUTE    = 3'd2;
	localparam logic [PC_W-1:0] STEP_ACK_ONLY = 3'd3;
	localparam logic [PC_W-1:0] STEP_STORE    = 3'd4;
	localparam logic [PC_W-1:0] STEP_ACK      = 3'd5;
	localparam logic [PC_W-1:0] STEP_DELIVER  = 3'd6;
	localparam logic [PC_W-1:0] STEP_SPARE    = 3'd7;

	// Jump conditions; COND_NEXT never jumps.
	typedef enum logic [2:0] {
		COND_NEXT       = 3'd0,
		COND_ALWAYS     = 3'd1,
		COND_NO_START   = 3'd2,
		COND_BAD        = 3'd3,
		COND_IN_WINDOW  = 3'd4,
		COND_BASE_EMPTY = 3'd5,
		COND_RUN_MORE   = 3'd6
	} srr_cond_t;

	// Source of the last-of-run mark on an emitted result.
	typedef enum logic [1:0] {
		LAST_ONE      = 2'd0,
		LAST_IF_EMPTY = 2'd1,
		LAST_RUN_END  = 2'd2
	} srr_last_t;

	// One control word of the program.
	typedef struct packed {
		logic              ready;
		logic              latch;
		srr_cond_t         cond;
		logic [PC_W-1:0]   target;
		logic              emit_ack;
		logic              emit_deliv;
		srr_last_t         last_sel;
		logic              store;
		logic              rd_next;
		logic              advance;
	} srr_ctl_t;

	// Status flags that the datapath returns for conditional jumps.
	typedef struct packed {
		logic bad;
		logic in_window;
		logic base_empty;
		logic run_end;
	} srr_flags_t;

	// Control program, one word per step.
	function automatic srr_ctl_t srr_program(input logic [PC_W-1:0] step);
		srr_ctl_t w;
		w = '0;
		w.cond     = COND_NEXT;
		w.last_sel = LAST_ONE;
		w.target   = STEP_WAIT;
		unique case (step)
			STEP_WAIT: begin
				w.ready = 1'b1;
				w.latch = 1'b1;
				w.cond  = COND_NO_START;
				w.target = STEP_WAIT;
			end
			STEP_SCREEN: begin
				w.cond   = COND_BAD;
				w.target = STEP_WAIT;
			end
			STEP_ROUTE: begin
				w.cond   = COND_IN_WINDOW;
				w.target = STEP_STORE;
			end
			STEP_ACK_ONLY: begin
				w.emit_ack = 1'b1;
				w.last_sel = LAST_ONE;
				w.cond     = COND_ALWAYS;
				w.target   = STEP_WAIT;
			end
			STEP_STORE: begin
				w.store = 1'b1;
			end
			STEP_ACK: begin
				w.emit_ack = 1'b1;
				w.last_sel = LAST_IF_EMPTY;
				w.cond     = COND_BASE_EMPTY;
				w.target   = STEP_WAIT;
			end
			// Stay on this step while the run goes on; fall through when it ends.
			STEP_DELIVER: begin
				w.emit_deliv = 1'b1;
				w.advance    = 1'b1;
				w.rd_next    = 1'b1;
				w.last_sel   = LAST_RUN_END;
				w.cond       = COND_RUN_MORE;
				w.target     = STEP_DELIVER;
			end
			STEP_SPARE: begin
				w.cond   = COND_ALWAYS;
				w.target = STEP_WAIT;
			end
		endcase
		return w;
	endfunction

endpackage

### hdl/selective_repeat_receiver.sv
// Top level of the selective-repeat receiver: sequencer plus datapath.
//
// Packets enter as command transactions: the block takes seq_number, payload_word
// and checksum_ok at a clock edge where start is high and busy is low.
// Results leave on result_kind, ack_number, delivered_word and last_of_run, each
// valid for exactly one cycle while result_strobe is high; the receiver of results
// cannot stall them, and the results of one packet come out in consecutive cycles.
// A corrupt packet produces nothing and holds busy only through the screen step.
// An out-of-window packet gives one ACK from the acknowledge-only step after the
// screen and route steps; busy is high through these steps.
// An in-window packet gives its ACK from the ack step after the screen, route and
// store steps, then one delivery per cycle for each buffered payload from the
// window base, at most seven; busy ends after the ACK step when nothing is
// delivered, otherwise after the delivery steps and the spare step.
// The rate is set by the microcoded step counter, which walks one slot of the
// payload RAM per cycle on its single read port.
// The user must write the window register via cfg_we and cfg_data only while busy is
// low; the block does not enforce it. Reset clears the slot marks, the window base
// and the sequencer at once and sets the window to four; no clearing pass is needed.
module selective_repeat_receiver import srr_pkg::*; #(
	parameter int SEQ_SPACE    = SEQ_SPACE_DEF,
	parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [WIN_W-1:0]  cfg_data,
	input  logic              start,
	output logic              busy,
	input  logic [SEQ_W-1:0]  seq_number,
	input  logic [WORD_W-1:0] payload_word,
	input  logic              checksum_ok,
	output logic              result_strobe,
	output logic              result_kind,
	output logic [SEQ_W-1:0]  ack_number,
	output logic [WORD_W-1:0] delivered_word,
	output logic              last_of_run
);

	srr_ctl_t   ctl;
	srr_flags_t flags;

	// Control program sequencer.
	srr_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.flags  (flags),
		.ctl    (ctl),
		.busy   (busy)
	);

	// Datapath with the slot store.
	srr_datapath #(
		.SEQ_SPACE    (SEQ_SPACE),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.flags          (flags),
		.start          (start),
		.seq_number     (seq_number),
		.payload_word   (payload_word),
		.checksum_ok    (checksum_ok),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.result_strobe  (result_strobe),
		.result_kind    (result_kind),
		.ack_number     (ack_number),
		.delivered_word (delivered_word),
		.last_of_run    (last_of_run)
	);

endmodule

### hdl/srr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module srr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hdl/srr_sequencer.sv
// Step counter and program ROM that drive the receiver datapath.
module srr_sequencer import srr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  srr_flags_t flags,
	output srr_ctl_t   ctl,
	output logic       busy
);

	logic [PC_W-1:0] pc_q;
	logic            take;

	// Fetch the control word of the current step.
	assign ctl  = srr_program(pc_q);
	assign busy = ~ctl.ready;

	// Evaluate the jump condition of the current step.
	always_comb begin
		unique case (ctl.cond)
			COND_NEXT:       take = 1'b0;
			COND_ALWAYS:     take = 1'b1;
			COND_NO_START:   take = ~start;
			COND_BAD:        take = flags.bad;
			COND_IN_WINDOW:  take = flags.in_window;
			COND_BASE_EMPTY: take = flags.base_empty;
			COND_RUN_MORE:   take = ~flags.run_end;
			default:         take = 1'b1;
		endcase
	end

	// Step counter: jump to the target or fall through to the next step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_WAIT;
		end else if (take) begin
			pc_q <= ctl.target;
		end else begin
			pc_q <= pc_q + PC_W'(1);
		end
	end

endmodule

### hdl/srr_datapath.sv
// Receiver datapath: packet latch, window check, slot marks, base pointer and result register.
module srr_datapath import srr_pkg::*; #(
	parameter int SEQ_SPACE    = SEQ_SPACE_DEF,
	parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  srr_ctl_t          ctl,
	output srr_flags_t        flags,
	input  logic              start,
	input  logic [SEQ_W-1:0]  seq_number,
	input  logic [WORD_W-1:0] payload_word,
	input  logic              checksum_ok,
	input  logic              cfg_we,
	input  logic [WIN_W-1:0]  cfg_data,
	output logic              result_strobe,
	output logic              result_kind,
	output logic [SEQ_W-1:0]  ack_number,
	output logic [WORD_W-1:0] delivered_word,
	output logic              last_of_run
);

	localparam int IDX_W = (SEQ_SPACE > 2) ? $clog2(SEQ_SPACE) : 1;
	localparam int CMP_W = ((IDX_W > SEQ_W) ? IDX_W : SEQ_W) + 1;
	localparam logic [CMP_W-1:0] SPACE_C = CMP_W'(SEQ_SPACE);
	localparam logic [CMP_W-1:0] LIMIT_C = CMP_W'(SEQ_SPACE - 1);
	localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(SEQ_SPACE - 1);

	logic [SEQ_W-1:0]        seq_q;
	logic [PAYLOAD_BITS-1:0] word_q;
	logic                    ok_q;
	logic [WIN_W-1:0]        win_q;
	logic [IDX_W-1:0]        base_q;
	logic [SEQ_SPACE-1:0]    valid_q;
	logic [CNT_W-1:0]        cnt_q;

	logic [CMP_W-1:0]        seq_c;
	logic [CMP_W-1:0]        base_c;
	logic [CMP_W-1:0]        seq_off;
	logic [CMP_W-1:0]        eff_win;
	logic [IDX_W-1:0]        slot_idx;
	logic [IDX_W-1:0]        base_next;
	logic [IDX_W-1:0]        rd_addr;
	logic [PAYLOAD_BITS-1:0] rd_data;
	logic                    run_end;
	logic                    last_bit;

	logic                    strobe_q;
	logic                    kind_q;
	logic [SEQ_W-1:0]        ack_q;
	logic [WORD_W-1:0]       word_out_q;
	logic                    last_q;

	// Window configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= WIN_W'(4);
		end else if (cfg_we) begin
			win_q <= cfg_data;
		end
	end

	// Capture the packet on the accepted start transaction.
	always_ff @(posedge clk) begin
		if (ctl.latch && start) begin
			seq_q  <= seq_number;
			word_q <= payload_word[PAYLOAD_BITS-1:0];
			ok_q   <= checksum_ok;
		end
	end

	// Window check: distance from the base modulo the sequence space.
	always_comb begin
		seq_c  = CMP_W'(seq_q);
		base_c = CMP_W'(base_q);
		if (seq_c >= base_c) begin
			seq_off = seq_c - base_c;
		end else begin
			seq_off = seq_c + SPACE_C - base_c;
		end
		eff_win = (CMP_W'(win_q) > LIMIT_C) ? LIMIT_C : CMP_W'(win_q);
	end

	assign slot_idx  = seq_c[IDX_W-1:0];
	assign base_next = (base_q == TOP_IDX) ? '0 : base_q + IDX_W'(1);
	assign rd_addr   = ctl.rd_next ? base_next : base_q;
	assign run_end   = (cnt_q == CNT_W'(MAX_DELIVER - 1)) || !valid_q[base_next];

	assign flags.bad        = ~ok_q;
	assign flags.in_window  = (seq_c < SPACE_C) && (seq_off < eff_win);
	assign flags.base_empty = ~valid_q[base_q];
	assign flags.run_end    = run_end;

	// Slot marks, base pointer and run counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			base_q  <= '0;
			cnt_q   <= '0;
		end else begin
			if (ctl.store) begin
				valid_q[slot_idx] <= 1'b1;
				cnt_q             <= '0;
			end
			if (ctl.advance) begin
				valid_q[base_q] <= 1'b0;
				base_q          <= base_next;
				cnt_q           <= cnt_q + CNT_W'(1);
			end
		end
	end

	// Buffered payload slots.
	srr_ram #(
		.WIDTH (PAYLOAD_BITS),
		.DEPTH (SEQ_SPACE)
	) u_slots (
		.clk   (clk),
		.we    (ctl.store),
		.waddr (slot_idx),
		.wdata (word_q),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// Last-of-run mark for the result being emitted.
	always_comb begin
		unique case (ctl.last_sel)
			LAST_ONE:      last_bit = 1'b1;
			LAST_IF_EMPTY: last_bit = ~valid_q[base_q];
			LAST_RUN_END:  last_bit = run_end;
			default:       last_bit = 1'b1;
		endcase
	end

	// Result strobe register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= ctl.emit_ack | ctl.emit_deliv;
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		kind_q     <= ctl.emit_deliv;
		ack_q      <= ctl.emit_ack ? seq_q : '0;
		word_out_q <= ctl.emit_deliv ? WORD_W'(rd_data) : '0;
		last_q     <= last_bit;
	end

	assign result_strobe  = strobe_q;
	assign result_kind    = kind_q;
	assign ack_number     = ack_q;
	assign delivered_word = word_out_q;
	assign last_of_run    = last_q;

`ifndef NO_ASSERTIONS
	// A delivery only ever releases a marked slot.
	a_deliver_marked: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit_deliv |-> valid_q[base_q])
		else $error("delivery from an unmarked slot");

	// Each delivery moves the base one step around the sequence space.
	a_base_steps: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit_deliv |=> base_q == $past(base_next))
		else $error("base did not advance after a delivery");

	// A run never exceeds its delivery limit.
	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit_deliv |-> cnt_q < CNT_W'(MAX_DELIVER))
		else $error("run longer than the delivery limit");

	// A result that is not the last of its run is followed at once by another.
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && !last_q) |=> strobe_q)
		else $error("run ended without a last-of-run mark");
`endif

endmodule

### tb/sv/tb_selective_repeat_receiver.sv
// Self-checking testbench for the selective-repeat receiver with its own packet predictor.
module tb_selective_repeat_receiver;
	import srr_pkg::*;

	localparam int SEQ_COUNT  = SEQ_SPACE_DEF;
	localparam int SETTLE     = 16;
	localparam int LIMIT      = 200000;
	localparam int GOOD_PER_PHASE = 42;

	typedef logic [SEQ_W-1:0]  seq_t;
	typedef logic [WORD_W-1:0] word_t;
	typedef logic [WIN_W-1:0]  win_t;

	typedef enum logic {
		KIND_ACK     = 1'b0,
		KIND_DELIVER = 1'b1
	} pkt_kind_t;

	typedef struct packed {
		pkt_kind_t kind;
		seq_t      ack;
		word_t     word;
		logic      last;
	} rx_result_t;

	logic clk;
	logic arst_n       = 1'b0;
	logic cfg_we       = 1'b0;
	win_t cfg_data     = '0;
	logic start        = 1'b0;
	seq_t seq_number   = '0;
	word_t payload_word = '0;
	logic checksum_ok  = 1'b0;
	logic busy;
	logic result_strobe;
	logic result_kind;
	seq_t ack_number;
	word_t delivered_word;
	logic last_of_run;

	// Predictor copy of the receiver state and its window register.
	win_t  rx_window;
	seq_t  rx_base;
	logic  slot_mark [SEQ_COUNT];
	word_t slot_data [SEQ_COUNT];

	rx_result_t awaited_results[$];
	int error_count = 0;
	int cycle_count = 0;
	int gap_max = 7;

	selective_repeat_receiver u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.start          (start),
		.busy           (busy),
		.seq_number     (seq_number),
		.payload_word   (payload_word),
		.checksum_ok    (checksum_ok),
		.result_strobe  (result_strobe),
		.result_kind    (result_kind),
		.ack_number     (ack_number),
		.delivered_word (delivered_word),
		.last_of_run    (last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// The run is cut off if it hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT) begin
			$display("tb_selective_repeat_receiver: done, errors");
			$finish;
		end
	end

	// Work out the results that one accepted packet causes and queue them.
	task automatic forecast_results(input seq_t seq, input word_t word, input logic ok);
		seq_t seq_off;
		int   run_len;
		logic more;
		seq_off = seq - rx_base;
		run_len = 0;
		if (ok) begin
			if (seq_off >= rx_window) begin
				// Outside the window the packet is only acknowledged.
				awaited_results.push_back('{KIND_ACK, seq, '0, 1'b1});
			end else begin
				slot_data[seq] = word;
				slot_mark[seq] = 1'b1;
				awaited_results.push_back('{KIND_ACK, seq, '0, !slot_mark[rx_base]});
				// Release the in-order run from the base, up to the delivery cap.
				more = slot_mark[rx_base];
				while (more) begin
					slot_mark[rx_base] = 1'b0;
					run_len++;
					more = (run_len < MAX_DELIVER) && slot_mark[seq_t'(rx_base + 1)];
					awaited_results.push_back('{KIND_DELIVER, '0, slot_data[rx_base], !more});
					rx_base = seq_t'(rx_base + 1);
				end
			end
		end
	endtask

	// Offer one packet after a random gap and wait until the block takes it.
	task automatic send_packet(input seq_t seq, input word_t word, input logic ok);
		int unsigned gap;
		gap = $urandom_range(0, gap_max);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start        <= 1'b1;
		seq_number   <= seq;
		payload_word <= word;
		checksum_ok  <= ok;
		do @(posedge clk); while (busy !== 1'b0);
		forecast_results(seq, word, ok);
	endtask

	// Stop sending and wait until every expected result has arrived, then settle.
	task automatic wait_for_quiet(input int settle);
		start <= 1'b0;
		do @(posedge clk); while (awaited_results.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	// Write the window register while the block is idle.
	task automatic set_window(input win_t value);
		wait_for_quiet(SETTLE);
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		rx_window = value;
		cfg_we <= 1'b0;
	endtask

	// Compare each result transaction with the oldest expectation.
	always @(posedge clk) begin : result_check
		rx_result_t want;
		if (arst_n && result_strobe === 1'b1) begin
			if (awaited_results.size() == 0) begin
				$error("unexpected result: kind %0d ack %0d word %h last %0d",
					result_kind, ack_number, delivered_word, last_of_run);
				error_count++;
			end else begin
				want = awaited_results.pop_front();
				if (result_kind !== want.kind) begin
					$error("result_kind: expected %0d, got %0d", want.kind, result_kind);
					error_count++;
				end
				if (ack_number !== want.ack) begin
					$error("ack_number: expected %0d, got %0d", want.ack, ack_number);
					error_count++;
				end
				if (delivered_word !== want.word) begin
					$error("delivered_word: expected %h, got %h", want.word, delivered_word);
					error_count++;
				end
				if (last_of_run !== want.last) begin
					$error("last_of_run: expected %0d, got %0d", want.last, last_of_run);
					error_count++;
				end
			end
		end
	end

	// Default window: out-of-window, buffering, corrupt, duplicate and in-order release.
	task automatic test_default_window();
		send_packet(seq_t'(4), {$urandom, $urandom}, 1'b1);
		send_packet(seq_t'(1), '1, 1'b1);
		send_packet(seq_t'(2), '0, 1'b1);
		send_packet(seq_t'(0), {$urandom, $urandom}, 1'b0);
		send_packet(seq_t'(0), 64'hA5A5_5A5A_F00D_0FF0, 1'b1);
		send_packet(seq_t'(1), {$urandom, $urandom}, 1'b1);
		send_packet(seq_t'(6), {$urandom, $urandom}, 1'b1);
		send_packet(seq_t'(6), {$urandom, $urandom}, 1'b1);
		send_packet(seq_t'(5), {$urandom, $urandom}, 1'b1);
		send_packet(seq_t'(3), {$urandom, $urandom}, 1'b1);
	endtask

	// Widest window: fill six slots ahead of the base, then release seven at once.
	task automatic test_widest_window();
		set_window(win_t'(7));
		for (int k = 1; k < 7; k++)
			send_packet(seq_t'(rx_base + k), {$urandom, $urandom}, 1'b1);
		send_packet(rx_base, {$urandom, $urandom}, 1'b1);
	endtask

	// Marks left beyond a shrunken window still take part in the run.
	task automatic test_shrunk_window();
		send_packet(seq_t'(rx_base + 1), {$urandom, $urandom}, 1'b1);
		send_packet(seq_t'(rx_base + 3), {$urandom, $urandom}, 1'b1);
		set_window(win_t'(1));
		send_packet(rx_base, {$urandom, $urandom}, 1'b1);
		send_packet(rx_base, {$urandom, $urandom}, 1'b1);
	endtask

	// An empty window acknowledges every good packet and stores nothing.
	task automatic test_zero_window();
		set_window(win_t'(0));
		send_packet(rx_base, {$urandom, $urandom}, 1'b1);
		send_packet(seq_t'(rx_base + 3), {$urandom, $urandom}, 1'b1);
	endtask

	// Random traffic over several window settings, mostly in-window packets.
	task automatic test_random_traffic();
		win_t  plan [8];
		int    good;
		int    r;
		seq_t  seq;
		logic  ok;
		plan = '{win_t'(7), win_t'(1), win_t'(0), win_t'($urandom_range(2, 6)), win_t'(4),
			win_t'($urandom_range(1, 7)), win_t'(3), win_t'(7)};
		for (int ph = 0; ph < 8; ph++) begin
			set_window(plan[ph]);
			gap_max = (ph % 2 == 0) ? 7 : 0;
			good = 0;
			while (good < GOOD_PER_PHASE) begin
				r  = $urandom_range(0, 99);
				ok = (r >= 15);
				if (r >= 15 && r < 80 && rx_window != 0)
					seq = seq_t'(rx_base + $urandom_range(0, rx_window - 1));
				else
					seq = seq_t'($urandom);
				send_packet(seq, {$urandom, $urandom}, ok);
				if (ok)
					good++;
				// Halfway through, hold off until the block has answered everything.
				if (good == GOOD_PER_PHASE / 2 && ok)
					wait_for_quiet(0);
			end
		end
		gap_max = 7;
	endtask

	initial begin
		rx_window = win_t'(4);
		rx_base   = '0;
		foreach (slot_mark[i]) begin
			slot_mark[i] = 1'b0;
			slot_data[i] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_window();
		test_widest_window();
		test_shrunk_window();
		test_zero_window();
		test_random_traffic();

		wait_for_quiet(SETTLE);
		if (error_count == 0)
			$display("tb_selective_repeat_receiver: done, clean");
		else
			$display("tb_selective_repeat_receiver: done, errors");
		$finish;
	end

endmodule
